[src/dtd_pkg.sv]
// Shared types and constants for the decimal text to double converter.
// No dependencies; dtd_dp, dtd_ctrl and the top level import this package.
`timescale 1ns / 1ps

package dtd_pkg;

  localparam int unsigned ExpW = 16;
  localparam int unsigned PowerSteps = 9;
  localparam int unsigned XW = PowerSteps;
  localparam logic [63:0] MantLimit = 64'd1844674407370955160;
  localparam logic [XW-1:0] MaxDecExp = XW'(511);

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_FEED,
    CMD_SETUP,
    CMD_NORM,
    CMD_MUL_START,
    CMD_MUL_STEP,
    CMD_MUL_END,
    CMD_DIV_START,
    CMD_DIV_STEP,
    CMD_DIV_END,
    CMD_SHIFTX,
    CMD_PACK
  } dp_op_e;

  typedef enum logic [1:0] {
    MSEL_SCALE,
    MSEL_POW,
    MSEL_FRAC
  } msel_e;

  typedef struct packed {
    dp_op_e     op;
    msel_e      msel;
    logic [1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic mant_zero;
    logic frac_top;
    logic x_zero;
    logic x_lsb;
    logic x_last;
    logic down;
    logic q_top;
  } dp_status_t;

endpackage

[src/dtd_if.sv]
// Valid/ready channel interfaces for input characters and result words.
// Depends on nothing.
`timescale 1ns / 1ps

interface dtd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface dtd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  modport source (output valid, output value_bits, input ready);
  modport sink (input valid, input value_bits, output ready);
endinterface

[src/dtd_dp.sv]
// Datapath: character parser registers, extended-precision multiply and
// divide units, and the final double packing. Depends on dtd_pkg.
`timescale 1ns / 1ps

module dtd_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dtd_pkg::dp_cmd_t    cmd_i,
  input  logic [7:0]          char_i,
  output dtd_pkg::dp_status_t status_o,
  output logic [63:0]         value_o
);
  import dtd_pkg::*;

  typedef enum logic [2:0] {
    PH_WS, PH_MANT, PH_INT, PH_FRAC, PH_ESIGN, PH_EDIG, PH_DONE
  } phase_e;

  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChDot = 8'h2E;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChLowE = 8'h65;
  localparam logic [7:0] ChUpE = 8'h45;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic signed [13:0] ShiftMax = 14'sd8191;
  localparam logic signed [13:0] ShiftMin = -14'sd8191 - 14'sd1;

  phase_e             phase_q, phase_d;
  logic               neg_q, neg_d;
  logic [63:0]        mant_q, mant_d;
  logic               pt_q, pt_d;
  logic signed [13:0] ds_q, ds_d;
  logic [15:0]        ev_q, ev_d;
  logic               eneg_q, eneg_d;

  logic [63:0]          frac_m_q, scale_m_q, pw_m_q;
  logic signed [ExpW-1:0] frac_e_q, scale_e_q, pw_e_q;
  logic [XW-1:0]        x_q;
  logic                 down_q;
  logic [63:0]          ma_q, mb_q;
  logic signed [ExpW-1:0] me_q;
  msel_e                mdst_q;
  logic [127:0]         acc_q;
  logic [63:0]          q_q, r_q, d_q;
  logic signed [ExpW-1:0] de_q;
  logic [63:0]          value_q;

  logic is_digit, is_space, is_exp;
  logic [3:0] dig;
  logic [19:0] nv;
  logic go;

  assign dig = 4'(char_i - ChZero);
  assign is_digit = (char_i >= ChZero) && (char_i <= ChNine);
  assign is_space = (char_i == ChSpace) || ((char_i >= ChTab) && (char_i <= ChCr));
  assign is_exp = (char_i == ChLowE) || (char_i == ChUpE);
  assign nv = 20'(ev_q) * 20'd10 + 20'(dig);

  always_comb begin
    phase_d = phase_q;
    neg_d = neg_q;
    mant_d = mant_q;
    pt_d = pt_q;
    ds_d = ds_q;
    ev_d = ev_q;
    eneg_d = eneg_q;
    go = 1'b1;
    if (phase_d == PH_WS) begin
      if (is_space) begin
        go = 1'b0;
      end else begin
        phase_d = PH_MANT;
        if (char_i == ChMinus) begin
          neg_d = 1'b1;
          go = 1'b0;
        end else if (char_i == ChPlus) begin
          go = 1'b0;
        end
      end
    end
    if (go && phase_d == PH_MANT) begin
      if (mant_q <= MantLimit) begin
        go = 1'b0;
        if (char_i == ChDot && !pt_q) begin
          pt_d = 1'b1;
        end else if (is_digit) begin
          mant_d = (mant_q << 3) + (mant_q << 1) + 64'(dig);
          if (pt_q && ds_q != ShiftMin) ds_d = ds_q - 14'sd1;
        end else begin
          phase_d = is_exp ? PH_ESIGN : PH_DONE;
        end
      end else begin
        phase_d = pt_q ? PH_FRAC : PH_INT;
      end
    end
    if (go && phase_d == PH_INT) begin
      go = 1'b0;
      if (is_digit) begin
        if (ds_q != ShiftMax) ds_d = ds_q + 14'sd1;
      end else if (char_i == ChDot) begin
        phase_d = PH_FRAC;
      end else begin
        phase_d = is_exp ? PH_ESIGN : PH_DONE;
      end
    end
    if (go && phase_d == PH_FRAC) begin
      go = 1'b0;
      if (!is_digit) phase_d = is_exp ? PH_ESIGN : PH_DONE;
    end
    if (go && phase_d == PH_ESIGN) begin
      phase_d = PH_EDIG;
      if (char_i == ChMinus) begin
        eneg_d = 1'b1;
        go = 1'b0;
      end else if (char_i == ChPlus) begin
        go = 1'b0;
      end
    end
    if (go && phase_d == PH_EDIG) begin
      if (is_digit) begin
        ev_d = (nv > 20'd65535) ? 16'hFFFF : nv[15:0];
      end else begin
        phase_d = PH_DONE;
      end
    end
  end

  // decimal exponent
  logic signed [17:0] xs;
  logic [17:0] xa;
  assign xs = 18'(ds_q) + (eneg_q ? -$signed({2'b00, ev_q}) : $signed({2'b00, ev_q}));
  assign xa = xs[17] ? 18'(-xs) : 18'(xs);

  // multiplier partial product and final normalize/round
  logic [63:0] pp;
  logic [127:0] pp_sh, prod;
  logic [63:0] mhi, mlo, mhi_r;
  logic signed [ExpW-1:0] me_r;
  logic mround;
  assign pp = 64'(ma_q[cmd_i.step[1]*32 +: 32]) * 64'(mb_q[cmd_i.step[0]*32 +: 32]);
  assign pp_sh = {64'b0, pp} << (7'(cmd_i.step[0]) + 7'(cmd_i.step[1])) * 7'd32;
  assign prod = acc_q[127] ? acc_q : (acc_q << 1);
  assign mhi = prod[127:64];
  assign mlo = prod[63:0];
  assign mround = mlo[63] && ((mlo[62:0] != 63'd0) || mhi[0]);

  always_comb begin
    mhi_r = mhi;
    me_r = acc_q[127] ? me_q : me_q - ExpW'(1);
    if (mround) begin
      mhi_r = mhi + 64'd1;
      if (mhi_r == 64'd0) begin
        mhi_r = 64'h8000_0000_0000_0000;
        me_r = me_r + ExpW'(1);
      end
    end
  end

  // divider step
  logic [64:0] rsh;
  logic rge;
  logic [63:0] rnext, qrnd;
  logic signed [ExpW-1:0] de_r;
  assign rsh = {r_q, 1'b0};
  assign rge = rsh >= {1'b0, d_q};
  assign rnext = rge ? 64'(rsh - {1'b0, d_q}) : rsh[63:0];

  always_comb begin
    qrnd = q_q;
    de_r = de_q;
    if (rge && (rnext != 64'd0 || q_q[0])) begin
      qrnd = q_q + 64'd1;
      if (qrnd == 64'd0) begin
        qrnd = 64'h8000_0000_0000_0000;
        de_r = de_q + ExpW'(1);
      end
    end
  end

  // pack to double
  logic [63:0] dbl, nq, sq, srem, shalf;
  logic [10:0] nrem;
  logic signed [ExpW-1:0] s;
  logic [63:0] nsum;
  always_comb begin
    nq = frac_m_q >> 11;
    nrem = frac_m_q[10:0];
    if (nrem > 11'h400 || (nrem == 11'h400 && nq[0])) nq = nq + 64'd1;
    nsum = {1'b0, 11'(frac_e_q + ExpW'(1085)), 52'd0} + nq;
    s = -frac_e_q - ExpW'(1074);
    sq = frac_m_q >> s[5:0];
    srem = frac_m_q & ((64'd1 << s[5:0]) - 64'd1);
    shalf = 64'd1 << (s[5:0] - 6'd1);
    if (srem > shalf || (srem == shalf && sq[0])) sq = sq + 64'd1;
    if (frac_e_q > ExpW'(960)) begin
      dbl = 64'h7FF0_0000_0000_0000;
    end else if (frac_e_q >= -ExpW'(1085)) begin
      dbl = (nsum >= 64'h7FF0_0000_0000_0000) ? 64'h7FF0_0000_0000_0000 : nsum;
    end else if (s > ExpW'(64)) begin
      dbl = 64'd0;
    end else if (s == ExpW'(64)) begin
      dbl = (frac_m_q > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
    end else begin
      dbl = sq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WS;
      neg_q <= 1'b0;
      mant_q <= '0;
      pt_q <= 1'b0;
      ds_q <= '0;
      ev_q <= '0;
      eneg_q <= 1'b0;
    end else if (cmd_i.op == CMD_FEED) begin
      phase_q <= phase_d;
      neg_q <= neg_d;
      mant_q <= mant_d;
      pt_q <= pt_d;
      ds_q <= ds_d;
      ev_q <= ev_d;
      eneg_q <= eneg_d;
    end else if (cmd_i.op == CMD_PACK) begin
      phase_q <= PH_WS;
      neg_q <= 1'b0;
      mant_q <= '0;
      pt_q <= 1'b0;
      ds_q <= '0;
      ev_q <= '0;
      eneg_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      CMD_SETUP: begin
        frac_m_q <= mant_q;
        frac_e_q <= '0;
        down_q <= xs[17];
        x_q <= (xa > 18'(MaxDecExp)) ? MaxDecExp : xa[XW-1:0];
        scale_m_q <= 64'h8000_0000_0000_0000;
        scale_e_q <= -ExpW'(63);
        pw_m_q <= 64'hA000_0000_0000_0000;
        pw_e_q <= -ExpW'(60);
      end
      CMD_NORM: begin
        if (frac_m_q[63:56] == 8'd0) begin
          frac_m_q <= frac_m_q << 8;
          frac_e_q <= frac_e_q - ExpW'(8);
        end else begin
          frac_m_q <= frac_m_q << 1;
          frac_e_q <= frac_e_q - ExpW'(1);
        end
      end
      CMD_MUL_START: begin
        acc_q <= '0;
        mdst_q <= cmd_i.msel;
        unique case (cmd_i.msel)
          MSEL_SCALE: begin
            ma_q <= scale_m_q;
            mb_q <= pw_m_q;
            me_q <= scale_e_q + pw_e_q + ExpW'(64);
          end
          MSEL_POW: begin
            ma_q <= pw_m_q;
            mb_q <= pw_m_q;
            me_q <= pw_e_q + pw_e_q + ExpW'(64);
          end
          default: begin
            ma_q <= frac_m_q;
            mb_q <= scale_m_q;
            me_q <= frac_e_q + scale_e_q + ExpW'(64);
          end
        endcase
      end
      CMD_MUL_STEP: acc_q <= acc_q + pp_sh;
      CMD_MUL_END: begin
        unique case (mdst_q)
          MSEL_SCALE: begin
            scale_m_q <= mhi_r;
            scale_e_q <= me_r;
          end
          MSEL_POW: begin
            pw_m_q <= mhi_r;
            pw_e_q <= me_r;
          end
          default: begin
            frac_m_q <= mhi_r;
            frac_e_q <= me_r;
          end
        endcase
      end
      CMD_DIV_START: begin
        d_q <= scale_m_q;
        de_q <= frac_e_q - scale_e_q;
        if (frac_m_q >= scale_m_q) begin
          q_q <= 64'd1;
          r_q <= frac_m_q - scale_m_q;
        end else begin
          q_q <= 64'd0;
          r_q <= frac_m_q;
        end
      end
      CMD_DIV_STEP: begin
        q_q <= {q_q[62:0], rge};
        r_q <= rnext;
        de_q <= de_q - ExpW'(1);
      end
      CMD_DIV_END: begin
        frac_m_q <= qrnd;
        frac_e_q <= de_r;
      end
      CMD_SHIFTX: x_q <= x_q >> 1;
      CMD_PACK: value_q <= {neg_q, 63'd0} | ((mant_q == 64'd0) ? 64'd0 : dbl);
      default: ;
    endcase
  end

  assign status_o.mant_zero = (mant_q == 64'd0);
  assign status_o.frac_top = frac_m_q[63];
  assign status_o.x_zero = (x_q == '0);
  assign status_o.x_lsb = x_q[0];
  assign status_o.x_last = (x_q[XW-1:1] == '0);
  assign status_o.down = down_q;
  assign status_o.q_top = q_q[63];
  assign value_o = value_q;

endmodule

[src/dtd_ctrl.sv]
// Controller: sequences parsing, normalization, power-of-ten scaling and
// packing, and holds the result valid flag. Depends on dtd_pkg.
`timescale 1ns / 1ps

module dtd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  dtd_pkg::dp_status_t status_i,
  output dtd_pkg::dp_cmd_t    cmd_o
);
  import dtd_pkg::*;

  typedef enum logic [3:0] {
    S_PARSE, S_CHECK, S_NORM, S_LOOP, S_MUL, S_MEND, S_SQ, S_SHIFT, S_DIV, S_PACK
  } state_e;

  state_e     state_q, state_d;
  msel_e      msel_q, msel_d;
  logic [1:0] step_q, step_d;
  logic       oval_q, oval_d;
  logic       out_free;

  assign out_free = !oval_q || out_ready_i;
  assign in_ready_o = (state_q == S_PARSE);
  assign out_valid_o = oval_q;

  always_comb begin
    state_d = state_q;
    msel_d = msel_q;
    step_d = step_q;
    oval_d = oval_q && !out_ready_i;
    cmd_o = '{op: CMD_IDLE, msel: msel_q, step: step_q};
    unique case (state_q)
      S_PARSE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_FEED;
          if (in_last_i) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.mant_zero) begin
          state_d = S_PACK;
        end else begin
          cmd_o.op = CMD_SETUP;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (status_i.frac_top) state_d = S_LOOP;
        else cmd_o.op = CMD_NORM;
      end
      S_LOOP: begin
        step_d = 2'd0;
        if (status_i.x_zero) begin
          if (status_i.down) begin
            cmd_o.op = CMD_DIV_START;
            state_d = S_DIV;
          end else begin
            cmd_o.op = CMD_MUL_START;
            cmd_o.msel = MSEL_FRAC;
            msel_d = MSEL_FRAC;
            state_d = S_MUL;
          end
        end else if (status_i.x_lsb) begin
          cmd_o.op = CMD_MUL_START;
          cmd_o.msel = MSEL_SCALE;
          msel_d = MSEL_SCALE;
          state_d = S_MUL;
        end else begin
          state_d = S_SQ;
        end
      end
      S_MUL: begin
        cmd_o.op = CMD_MUL_STEP;
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) state_d = S_MEND;
      end
      S_MEND: begin
        cmd_o.op = CMD_MUL_END;
        unique case (msel_q)
          MSEL_SCALE: state_d = S_SQ;
          MSEL_POW: state_d = S_SHIFT;
          default: state_d = S_PACK;
        endcase
      end
      S_SQ: begin
        step_d = 2'd0;
        if (status_i.x_last) begin
          cmd_o.op = CMD_SHIFTX;
          state_d = S_LOOP;
        end else begin
          cmd_o.op = CMD_MUL_START;
          cmd_o.msel = MSEL_POW;
          msel_d = MSEL_POW;
          state_d = S_MUL;
        end
      end
      S_SHIFT: begin
        cmd_o.op = CMD_SHIFTX;
        state_d = S_LOOP;
      end
      S_DIV: begin
        if (status_i.q_top) begin
          cmd_o.op = CMD_DIV_END;
          state_d = S_PACK;
        end else begin
          cmd_o.op = CMD_DIV_STEP;
        end
      end
      S_PACK: begin
        if (out_free) begin
          cmd_o.op = CMD_PACK;
          oval_d = 1'b1;
          state_d = S_PARSE;
        end
      end
      default: state_d = S_PARSE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_PARSE;
      msel_q <= MSEL_SCALE;
      step_q <= 2'd0;
      oval_q <= 1'b0;
    end else begin
      state_q <= state_d;
      msel_q <= msel_d;
      step_q <= step_d;
      oval_q <= oval_d;
    end
  end

endmodule

[src/decimal_text_to_double_core.sv]
// Decimal text to IEEE 754 double converter, top level.
// Depends on dtd_pkg, dtd_if, dtd_ctrl and dtd_dp.
// Characters are taken one per cycle while a string is parsed. After the byte
// marked last, the block stops taking input and computes the result: a setup
// step, mantissa normalization, then up to nine power-of-ten rounds in the
// shared 32x32 multiplier, where one multiply has the steps start, four partial
// products and round, then a final multiply or a bit-serial divide, and a
// packing step; a zero mantissa goes straight to packing. The result word sits
// in an output register, so the next string is taken as soon as that register
// has been loaded.
`timescale 1ns / 1ps

module decimal_text_to_double_core (
  input logic       clk_i,
  input logic       rst_ni,
  dtd_in_if.sink    in_i,
  dtd_out_if.source out_o
);
  import dtd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dtd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_char),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dtd_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .char_i   (in_i.char_code),
    .status_o (status),
    .value_o  (out_o.value_bits)
  );

endmodule

[tb/dtd_value_check.sv]
// Watches the character and result channels of the decimal text to double converter,
// predicts the double of every string and compares it with each result word.
// Depends on dtd_in_if and dtd_out_if.
`timescale 1ns / 1ps

module dtd_value_check (
  input  logic clk_i,
  input  logic rst_ni,
  dtd_in_if    in_w,
  dtd_out_if   out_w,
  output int   fail_count_o,
  output int   pending_o
);

  typedef enum logic [2:0] {
    PH_WS, PH_MANT, PH_INT, PH_FRAC, PH_ESIGN, PH_EDIG, PH_DONE
  } phase_e;

  typedef struct {
    logic [63:0] m;
    int          e;
  } xval_t;

  localparam logic [63:0] MantCap = 64'd1844674407370955160;

  phase_e      phase;
  logic        neg;
  logic [63:0] mant;
  logic        point;
  int          shift;
  int          expv;
  logic        exp_neg;
  logic [63:0] double_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = double_q.size();

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_exp(logic [7:0] c);
    return c == "e" || c == "E";
  endfunction

  function automatic xval_t x_mul(xval_t a, xval_t b);
    logic [127:0] p;
    logic [63:0]  hi, lo;
    xval_t        r;
    p = a.m * b.m;
    hi = p[127:64];
    lo = p[63:0];
    r.e = a.e + b.e + 64;
    if (!hi[63]) begin
      hi = {hi[62:0], lo[63]};
      lo = lo << 1;
      r.e -= 1;
    end
    if (lo[63] && (lo[62:0] != 0 || hi[0])) begin
      hi++;
      if (hi == 0) begin
        hi = 64'h8000_0000_0000_0000;
        r.e += 1;
      end
    end
    r.m = hi;
    return r;
  endfunction

  function automatic xval_t x_div(xval_t a, xval_t b);
    logic [63:0] q, r, d;
    logic        carry, rb;
    int          f;
    xval_t       res;
    q = 0;
    r = a.m;
    d = b.m;
    f = 0;
    if (r >= d) begin
      q = 1;
      r -= d;
    end
    while (!q[63]) begin
      carry = r[63];
      r = r << 1;
      q = q << 1;
      if (carry || r >= d) begin
        q[0] = 1'b1;
        r -= d;
      end
      f++;
    end
    carry = r[63];
    r = r << 1;
    rb = carry || r >= d;
    if (rb) r -= d;
    res.e = a.e - b.e - f;
    if (rb && (r != 0 || q[0])) begin
      q++;
      if (q == 0) begin
        q = 64'h8000_0000_0000_0000;
        res.e += 1;
      end
    end
    res.m = q;
    return res;
  endfunction

  function automatic logic [63:0] to_double(xval_t v);
    int          big_e, s;
    logic [63:0] q, rem, half;
    big_e = v.e + 63;
    if (big_e > 1023) return 64'h7FF0_0000_0000_0000;
    if (big_e >= -1022) begin
      q = v.m >> 11;
      rem = v.m & 64'h7FF;
      if (rem > 64'h400 || (rem == 64'h400 && q[0])) q++;
      q = (64'(big_e + 1022) << 52) + q;
      if (q >= 64'h7FF0_0000_0000_0000) return 64'h7FF0_0000_0000_0000;
      return q;
    end
    s = -(v.e + 1074);
    if (s > 64) return 0;
    if (s == 64) return (v.m > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
    q = v.m >> s;
    rem = v.m & ((64'd1 << s) - 1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && q[0])) q++;
    return q;
  endfunction

  function automatic logic [63:0] string_value();
    xval_t frac, scale, pw;
    int    x, lead;
    logic  down;
    if (mant == 0) return {neg, 63'd0};
    lead = 0;
    while (!((mant << lead) >> 63)) lead++;
    frac.m = mant << lead;
    frac.e = -lead;
    x = shift + (exp_neg ? -expv : expv);
    down = x < 0;
    if (down) x = -x;
    if (x > 511) x = 511;
    scale.m = 64'h8000_0000_0000_0000;
    scale.e = -63;
    pw.m = 64'd10 << 60;
    pw.e = -60;
    for (int i = 0; i < 9 && x != 0; i++) begin
      if (x & 1) scale = x_mul(scale, pw);
      pw = x_mul(pw, pw);
      x >>= 1;
    end
    frac = down ? x_div(frac, scale) : x_mul(frac, scale);
    return {neg, 63'd0} | to_double(frac);
  endfunction

  task automatic clear_parse();
    phase = PH_WS;
    neg = 0;
    mant = 0;
    point = 0;
    shift = 0;
    expv = 0;
    exp_neg = 0;
  endtask

  task automatic take_char(logic [7:0] c);
    int nv;
    if (phase == PH_WS) begin
      if (c == " " || (c >= 9 && c <= 13)) return;
      phase = PH_MANT;
      if (c == "-") begin
        neg = 1;
        return;
      end
      if (c == "+") return;
    end
    if (phase == PH_MANT) begin
      if (mant <= MantCap) begin
        if (c == "." && !point) begin
          point = 1;
          return;
        end
        if (is_digit(c)) begin
          mant = mant * 10 + 64'(c - "0");
          if (point && shift > -8192) shift--;
          return;
        end
        phase = is_exp(c) ? PH_ESIGN : PH_DONE;
        return;
      end
      phase = point ? PH_FRAC : PH_INT;
    end
    if (phase == PH_INT) begin
      if (is_digit(c)) begin
        if (shift < 8191) shift++;
        return;
      end
      if (c == ".") begin
        phase = PH_FRAC;
        return;
      end
      phase = is_exp(c) ? PH_ESIGN : PH_DONE;
      return;
    end
    if (phase == PH_FRAC) begin
      if (is_digit(c)) return;
      phase = is_exp(c) ? PH_ESIGN : PH_DONE;
      return;
    end
    if (phase == PH_ESIGN) begin
      phase = PH_EDIG;
      if (c == "-") begin
        exp_neg = 1;
        return;
      end
      if (c == "+") return;
    end
    if (phase == PH_EDIG) begin
      if (is_digit(c)) begin
        nv = expv * 10 + (c - "0");
        expv = nv > 65535 ? 65535 : nv;
        return;
      end
      phase = PH_DONE;
    end
  endtask

  initial begin
    clear_parse();
    fails = 0;
  end

  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni) begin
      if (in_w.valid && in_w.ready) begin
        take_char(in_w.char_code);
        if (in_w.last_char) begin
          double_q.push_back(string_value());
          clear_parse();
        end
      end
      if (out_w.valid && out_w.ready) begin
        if (double_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result word %h", out_w.value_bits);
        end else begin
          want = double_q.pop_front();
          if (want !== out_w.value_bits) begin
            fails++;
            if (fails <= 10)
              $display("value_bits mismatch: expected %h actual %h", want, out_w.value_bits);
          end
        end
      end
    end
  end

endmodule

[tb/tb_top.sv]
// Stimulus and verdict for decimal_text_to_double_core: sends directed and random
// strings with random idling and stalls. Depends on dtd_if, the core and dtd_value_check.
`timescale 1ns / 1ps

module tb_top;

  localparam int TargetWords = 1650;
  localparam int StallLimit  = 3000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   words_sent;
  logic idle_on;
  logic hold_req;
  logic hold_done;

  dtd_in_if  in_w ();
  dtd_out_if out_w ();

  decimal_text_to_double_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_w),
    .out_o (out_w)
  );

  dtd_value_check u_value_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_w        (in_w),
    .out_w       (out_w),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_word(logic [7:0] c, logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_w.valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_w.valid     <= 1;
    in_w.char_code <= c;
    in_w.last_char <= last;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  task automatic add_digits(ref logic [7:0] t[$], input int n);
    repeat (n) t.push_back(8'("0") + 8'($urandom_range(0, 9)));
  endtask

  task automatic send_random_string();
    logic [7:0] t[$];
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
        t.push_back($urandom_range(0, 1) ? 8'd32 : 8'($urandom_range(9, 13)));
      case ($urandom_range(0, 2))
        0: t.push_back("-");
        1: t.push_back("+");
        default: ;
      endcase
      add_digits(t, $urandom_range(0, 3) == 0 ? $urandom_range(15, 28) : $urandom_range(0, 8));
      if ($urandom_range(0, 1)) begin
        t.push_back(".");
        add_digits(t, $urandom_range(0, 12));
      end
      if ($urandom_range(0, 1)) begin
        t.push_back($urandom_range(0, 1) ? "e" : "E");
        case ($urandom_range(0, 2))
          0: t.push_back("-");
          1: t.push_back("+");
          default: ;
        endcase
        add_digits(t, $urandom_range(0, 4) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 3));
      end
      if ($urandom_range(0, 9) == 0) t.push_back(8'($urandom_range(0, 255)));
      if (t.size() == 0) t.push_back("0");
    end else begin
      repeat ($urandom_range(1, 10)) t.push_back(8'($urandom_range(0, 255)));
    end
    foreach (t[i]) send_word(t[i], i == t.size() - 1);
  endtask

  initial begin
    int strings;
    rst_ni = 0;
    in_w.valid = 0;
    in_w.char_code = 0;
    in_w.last_char = 0;
    out_w.ready = 0;
    idle_on = 1;
    hold_req = 0;
    words_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_text("-0");
    send_text("1e999");
    send_text(" +.5E-3");
    send_text("4e-324");
    send_text("1x2");
    send_word(8'd0, 1);
    send_word(8'd200, 1);
    send_text("1.5.2");
    strings = 0;
    while (words_sent < TargetWords) begin
      if (strings == 30) hold_req <= 1;
      if (strings == 70) begin
        in_w.valid <= 0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      if (words_sent > TargetWords - 250) idle_on = 0;
      send_random_string();
      strings++;
    end
    in_w.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    hold_done = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        out_w.ready <= 0;
        repeat (600) @(posedge clk_i);
        hold_done = 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_w.ready <= 0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_w.ready <= 1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
src/dtd_pkg.sv
src/dtd_if.sv
src/dtd_dp.sv
src/dtd_ctrl.sv
src/decimal_text_to_double_core.sv
tb/dtd_value_check.sv
tb/tb_top.sv
